FILE: hw/rtl/pndr_pkg.sv
// ----------------------------------------------------------------------------
// Pad note engine package
// Shared types and constants for the pad note delay and release block.
// ----------------------------------------------------------------------------
package pndr_pkg;

  localparam int PAD_COUNT     = 9;
  localparam int SLOTS_PER_PAD = 8;
  localparam int QUEUE_DEPTH   = 32;
  localparam int PAD_W   = 4;
  localparam int SLOT_W  = 3;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int TBL_DEPTH = PAD_COUNT * SLOTS_PER_PAD;
  localparam int TBL_AW  = $clog2(TBL_DEPTH);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [7:0] NOTE_NONE = 8'd128;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ON   = 2'd0,
    KIND_OFF  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_SEND_DELAY = 1'd0,
    REG_CHANNEL    = 1'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_CHK,
    ST_ON_RD,
    ST_ON_CHK,
    ST_OFF_RD,
    ST_OFF_CHK,
    ST_OFF_SCAN_RD,
    ST_OFF_SCAN_CHK,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] pad;
    logic [6:0] velocity;
    logic [2:0] slot;
    logic [7:0] note_value;
    logic       send_enable;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] channel;
    logic [6:0] note_number;
    logic [6:0] note_velocity;
    logic       last;
  } out_item_t;

endpackage

FILE: hw/rtl/pndr_if.sv
// ----------------------------------------------------------------------------
// Pad note engine channel
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface pndr_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/pad_note_delay_and_release.sv
// ----------------------------------------------------------------------------
// Pad note delay and release
// Queues pad presses, releases delayed note-ons on ticks and sends note-offs
// for released pads unless another pressed pad holds the same note in the same slot.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   cmd, pad, velocity, slot, note_value, send_enable
// out_ch    out  kind, channel, note_number, note_velocity, last
// cfg       in   cfg_we, cfg_idx, cfg_data (send_delay_ms, midi_channel)
//
// After reset the note table is swept to blank, one entry a cycle,
// with in_ch.ready low. A tick reads the queue head, checks it and, if it is
// due, walks the pad's slots; a release walks the pad's slots and, for each
// non-blank slot, scans the pads through the single table read port. Each
// result waits in the output register until taken; the sequencer stalls.
module pad_note_delay_and_release (
  input  logic clk,
  input  logic rst,
  pndr_if.sink   in_ch,
  pndr_if.source out_ch,
  input  logic                              cfg_we,
  input  logic [pndr_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pndr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pndr_pkg::*;

  state_t state, state_next;

  logic [7:0]  tbl [TBL_DEPTH];
  logic [7:0]  tbl_q;
  logic [TBL_AW-1:0] tbl_ra;

  logic [3:0]  q_pad [QUEUE_DEPTH];
  logic [6:0]  q_vel [QUEUE_DEPTH];
  logic [31:0] q_stamp [QUEUE_DEPTH];
  logic [3:0]  qp_q;
  logic [6:0]  qv_q;
  logic [31:0] qs_q;

  logic [QPTR_W-1:0] head, tail;
  logic [31:0] time_ms;
  logic [9:0]  send_delay;
  logic [3:0]  midi_ch;
  logic [PAD_COUNT-1:0] enable_bits, pressed;

  logic [3:0]  wpad;      // pad being emitted
  logic [6:0]  wvel;
  logic [SLOT_W:0] slot_c;
  logic [3:0]  scan_j;
  logic [7:0]  cur_note;
  logic [TBL_AW:0] clr_cnt;

  out_item_t   obuf;
  logic        ovalid;

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE) && !ovalid;
  assign out_ch.valid = ovalid;
  assign out_ch.data  = obuf;

  logic [QPTR_W-1:0] head_inc, tail_inc;
  assign head_inc = (head == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : tail + 1'b1;

  logic slot_done;
  assign slot_done = (slot_c == (SLOT_W+1)'(SLOTS_PER_PAD));

  // Is any later non-blank slot left? Determined by walking; we mark last
  // by looking ahead: emit is deferred until the next candidate is found.
  logic        pend;       // one result held back to learn if it is last
  out_item_t   pend_item;
  out_item_t   pend_last;

  always_comb begin
    pend_last = pend_item;
    pend_last.last = 1'b1;
  end

  logic [31:0] age;
  assign age = time_ms - qs_q;

  always_comb begin
    tbl_ra = '0;
    unique case (state)
      ST_OFF_SCAN_RD, ST_OFF_SCAN_CHK:
        tbl_ra = TBL_AW'(scan_j * SLOTS_PER_PAD) + TBL_AW'(slot_c);
      default:        tbl_ra = TBL_AW'(wpad * SLOTS_PER_PAD) + TBL_AW'(slot_c);
    endcase
  end

  always_ff @(posedge clk) begin
    tbl_q <= tbl[tbl_ra];
    qp_q <= q_pad[tail];
    qv_q <= q_vel[tail];
    qs_q <= q_stamp[tail];
    if (state == ST_CLEAR) begin
      tbl[clr_cnt[TBL_AW-1:0]] <= NOTE_NONE;
    end else if (acc && in_ch.data.cmd == CMD_LOAD && in_ch.data.pad < PAD_COUNT
                 && 32'(in_ch.data.slot) < SLOTS_PER_PAD) begin
      tbl[TBL_AW'(in_ch.data.pad * SLOTS_PER_PAD) + TBL_AW'(in_ch.data.slot)] <=
        (in_ch.data.note_value > 8'd127) ? NOTE_NONE : in_ch.data.note_value;
    end
    if (acc && in_ch.data.cmd == CMD_PRESS && in_ch.data.pad < PAD_COUNT
        && head_inc != tail) begin
      q_pad[head]   <= in_ch.data.pad;
      q_vel[head]   <= in_ch.data.velocity;
      q_stamp[head] <= time_ms;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == (TBL_AW+1)'(TBL_DEPTH-1)) state_next = ST_IDLE;
      ST_IDLE: if (acc) begin
        if (in_ch.data.cmd == CMD_TICK) state_next = ST_TICK_RD;
        else if (in_ch.data.cmd == CMD_RELEASE && in_ch.data.pad < PAD_COUNT
                 && enable_bits[in_ch.data.pad]) state_next = ST_OFF_RD;
      end
      ST_TICK_RD:  state_next = ST_TICK_CHK;
      ST_TICK_CHK: begin
        if (head != tail && age >= 32'(send_delay) && qp_q < PAD_COUNT
            && enable_bits[qp_q]) state_next = ST_ON_RD;
        else state_next = ST_IDLE;
      end
      ST_ON_RD, ST_OFF_RD: state_next = slot_done ? ST_EMIT :
                           (state == ST_ON_RD ? ST_ON_CHK : ST_OFF_CHK);
      ST_ON_CHK: if (!(pend && ovalid)) state_next = ST_ON_RD;
      ST_OFF_CHK: begin
        if (tbl_q == NOTE_NONE) state_next = ST_OFF_RD;
        else state_next = ST_OFF_SCAN_RD;
      end
      ST_OFF_SCAN_RD: state_next = ST_OFF_SCAN_CHK;
      ST_OFF_SCAN_CHK: begin
        if (hit) state_next = ST_OFF_RD;
        else if (scan_j == 4'(PAD_COUNT-1)) begin
          if (!(pend && ovalid)) state_next = ST_OFF_RD;
        end else state_next = ST_OFF_SCAN_RD;
      end
      ST_EMIT: if (!ovalid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Candidate result produced this cycle, if any.
  logic      cand;
  out_item_t cand_item;
  logic      hit;
  always_comb begin
    hit = (scan_j != wpad) && pressed[scan_j] && (tbl_q == cur_note);
    cand = 1'b0;
    cand_item = '0;
    cand_item.channel = midi_ch;
    cand_item.note_number = cur_note[6:0];
    if (state == ST_ON_CHK && tbl_q != NOTE_NONE && !(pend && ovalid)) begin
      cand = 1'b1;
      cand_item.kind = KIND_ON;
      cand_item.note_number = tbl_q[6:0];
      cand_item.note_velocity = wvel;
    end else if (state == ST_OFF_SCAN_CHK && !hit && scan_j == 4'(PAD_COUNT-1)
                 && !(pend && ovalid)) begin
      cand = 1'b1;
      cand_item.kind = KIND_OFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      head <= '0;
      tail <= '0;
      time_ms <= '0;
      send_delay <= 10'd5;
      midi_ch <= '0;
      enable_bits <= '0;
      pressed <= '0;
      ovalid <= 1'b0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_idx))
          REG_SEND_DELAY: send_delay <= cfg_data[9:0];
          REG_CHANNEL:    midi_ch <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) ovalid <= 1'b0;

      if (acc) begin
        wpad <= in_ch.data.pad;
        slot_c <= '0;
        pend <= 1'b0;
        unique case (cmd_t'(in_ch.data.cmd))
          CMD_PRESS: if (in_ch.data.pad < PAD_COUNT) begin
            pressed[in_ch.data.pad] <= 1'b1;
            if (head_inc == tail) begin
              ovalid <= 1'b1;
              obuf <= '{kind: KIND_DROP, channel: midi_ch, note_number: '0,
                        note_velocity: '0, last: 1'b1};
            end else head <= head_inc;
          end
          CMD_RELEASE: if (in_ch.data.pad < PAD_COUNT)
            pressed[in_ch.data.pad] <= 1'b0;
          CMD_TICK: time_ms <= time_ms + 1'b1;
          CMD_LOAD: if (in_ch.data.pad < PAD_COUNT)
            enable_bits[in_ch.data.pad] <= in_ch.data.send_enable;
          default: ;
        endcase
      end

      if (state == ST_TICK_CHK && head != tail && age >= 32'(send_delay)) begin
        tail <= tail_inc;
        wpad <= qp_q;
        wvel <= qv_q;
      end
      if (state == ST_ON_CHK && !(pend && ovalid)) slot_c <= slot_c + 1'b1;
      if (state == ST_OFF_CHK) begin
        cur_note <= tbl_q;
        scan_j <= '0;
        if (tbl_q == NOTE_NONE) slot_c <= slot_c + 1'b1;
      end
      if (state == ST_OFF_SCAN_CHK) begin
        if (hit) begin
          slot_c <= slot_c + 1'b1;
        end else if (scan_j == 4'(PAD_COUNT-1)) begin
          if (!(pend && ovalid)) slot_c <= slot_c + 1'b1;
        end else scan_j <= scan_j + 1'b1;
      end
      if (cand) begin
        // Hand the previous held-back result out; keep the new one back.
        if (pend) begin
          obuf <= pend_item;
          ovalid <= 1'b1;
        end
        pend <= 1'b1;
        pend_item <= cand_item;
      end
      if (state == ST_EMIT && !ovalid) begin
        if (pend) begin
          obuf <= pend_last;
          ovalid <= 1'b1;
        end
        pend <= 1'b0;
      end
    end
  end

endmodule

FILE: sim/tb_pad_note_delay_and_release.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pad note delay and release testbench
// Drives table loads, presses, ticks and releases into the pad note engine,
// predicts every note-on, note-off and dropped-press event in a scoreboard,
// and checks each event field by field. The run steps through several delay
// and channel settings and through phases of sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_pad_note_delay_and_release;
  import pndr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_COUNT = 5;

  class note_scoreboard;
    logic [7:0] note_table [TBL_DEPTH];
    bit [PAD_COUNT-1:0] enable_bits;
    bit [PAD_COUNT-1:0] pressed_pads;
    bit [3:0] fifo_pad [QUEUE_DEPTH];
    bit [6:0] fifo_vel [QUEUE_DEPTH];
    bit [31:0] fifo_stamp [QUEUE_DEPTH];
    int fifo_head;
    int fifo_tail;
    bit [31:0] now_ms;
    bit [9:0] send_delay;
    bit [3:0] channel;
    out_item_t expected_events[$];
    int errors;
    int items_seen;
    int ons_seen;
    int offs_seen;
    int drops_seen;

    function new();
      foreach (note_table[i]) note_table[i] = NOTE_NONE;
      enable_bits = '0;
      pressed_pads = '0;
      fifo_head = 0;
      fifo_tail = 0;
      now_ms = '0;
      send_delay = 10'd5;
      channel = 4'd0;
      errors = 0;
    endfunction

    function void push_event(kind_t k, logic [7:0] note, logic [6:0] vel);
      out_item_t ev;
      ev.kind = k;
      ev.channel = channel;
      ev.note_number = note[6:0];
      ev.note_velocity = vel;
      ev.last = 1'b0;
      expected_events.push_back(ev);
    endfunction

    function void note_input(in_item_t it);
      int before_count;
      int nx;
      int p;
      bit held;
      logic [7:0] note;
      before_count = expected_events.size();
      items_seen++;
      case (cmd_t'(it.cmd))
        CMD_PRESS: if (it.pad < PAD_COUNT) begin
          pressed_pads[it.pad] = 1'b1;
          nx = (fifo_head + 1) % QUEUE_DEPTH;
          if (nx == fifo_tail) begin
            push_event(KIND_DROP, 8'd0, 7'd0);
          end else begin
            fifo_pad[fifo_head] = it.pad;
            fifo_vel[fifo_head] = it.velocity;
            fifo_stamp[fifo_head] = now_ms;
            fifo_head = nx;
          end
        end
        CMD_RELEASE: if (it.pad < PAD_COUNT) begin
          pressed_pads[it.pad] = 1'b0;
          if (enable_bits[it.pad]) begin
            for (int s = 0; s < SLOTS_PER_PAD; s++) begin
              note = note_table[it.pad * SLOTS_PER_PAD + s];
              if (note == NOTE_NONE) continue;
              // A note stays on if another pressed pad has it in the same slot.
              held = 1'b0;
              for (int j = 0; j < PAD_COUNT; j++)
                if (j != it.pad && pressed_pads[j] &&
                    note_table[j * SLOTS_PER_PAD + s] == note) held = 1'b1;
              if (!held) push_event(KIND_OFF, note, 7'd0);
            end
          end
        end
        CMD_TICK: begin
          now_ms++;
          if (fifo_head != fifo_tail &&
              (now_ms - fifo_stamp[fifo_tail]) >= {22'd0, send_delay}) begin
            p = int'(fifo_pad[fifo_tail]);
            if (enable_bits[p])
              for (int s = 0; s < SLOTS_PER_PAD; s++) begin
                note = note_table[p * SLOTS_PER_PAD + s];
                if (note != NOTE_NONE) push_event(KIND_ON, note, fifo_vel[fifo_tail]);
              end
            fifo_tail = (fifo_tail + 1) % QUEUE_DEPTH;
          end
        end
        default: if (it.pad < PAD_COUNT) begin
          note_table[it.pad * SLOTS_PER_PAD + it.slot] =
            (it.note_value > 8'd127) ? NOTE_NONE : it.note_value;
          enable_bits[it.pad] = it.send_enable;
        end
      endcase
      if (expected_events.size() > before_count)
        expected_events[expected_events.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_events.size() == 0) begin
        $error("event with nothing expected: kind %0d note %0d", got.kind, got.note_number);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      compare_field("kind", int'(want.kind), int'(got.kind));
      compare_field("channel", int'(want.channel), int'(got.channel));
      compare_field("note_number", int'(want.note_number), int'(got.note_number));
      compare_field("note_velocity", int'(want.note_velocity), int'(got.note_velocity));
      compare_field("last", int'(want.last), int'(got.last));
      case (kind_t'(got.kind))
        KIND_ON: ons_seen++;
        KIND_OFF: offs_seen++;
        default: drops_seen++;
      endcase
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  note_scoreboard sb;

  pndr_if #(.payload_t(in_item_t)) in_ch ();
  pndr_if #(.payload_t(out_item_t)) out_ch ();

  pad_note_delay_and_release u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk)
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_cmd(cmd_t c, int pad, int vel, int slot, int nv, bit en);
    in_item_t it;
    it.cmd = c;
    it.pad = 4'(pad);
    it.velocity = 7'(vel);
    it.slot = 3'(slot);
    it.note_value = 8'(nv);
    it.send_enable = en;
    send_item(it);
  endtask

  task automatic write_reg(reg_idx_t idx, int value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SEND_DELAY) sb.send_delay = 10'(value);
    else sb.channel = 4'(value);
  endtask

  // The block may still be scanning after the last event arrives.
  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (sb.expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_note();
    int pool [4] = '{60, 64, 0, 127};
    if ($urandom_range(1)) return pool[$urandom_range(3)];
    return $urandom_range(255);
  endfunction

  function automatic int pick_pad();
    return ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(PAD_COUNT - 1);
  endfunction

  task automatic random_phase(int target);
    int sent;
    int r;
    int p;
    sent = 0;
    while (sent < target) begin
      r = $urandom_range(9);
      p = pick_pad();
      if (r < 2) begin
        send_cmd(CMD_LOAD, p, $urandom_range(127), $urandom_range(7), pick_note(),
                 $urandom_range(3) != 0);
        sent++;
      end else if (r < 8) begin
        // Press, some ticks, then mostly a release: the usual life of a pad.
        send_cmd(CMD_PRESS, p, $urandom_range(127), $urandom_range(7), $urandom_range(255),
                 1'($urandom_range(1)));
        sent++;
        repeat ($urandom_range(6)) begin
          send_cmd(CMD_TICK, $urandom_range(15), $urandom_range(127), $urandom_range(7),
                   $urandom_range(255), 1'($urandom_range(1)));
          sent++;
        end
        if ($urandom_range(3) != 0) begin
          send_cmd(CMD_RELEASE, p, $urandom_range(127), $urandom_range(7),
                   $urandom_range(255), 1'($urandom_range(1)));
          sent++;
        end
      end else begin
        send_cmd(cmd_t'($urandom_range(3)), pick_pad(), $urandom_range(127),
                 $urandom_range(7), $urandom_range(255), 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  initial begin
    static int delays [PHASE_COUNT] = '{5, 0, 1023, 2, 1};
    static int chans [PHASE_COUNT] = '{0, 15, 9, 3, 1};
    static int send_pcts [PHASE_COUNT] = '{0, 72, 0, 14, 0};
    static int recv_pcts [PHASE_COUNT] = '{0, 0, 72, 14, 0};
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: table extremes, a shared note, disabled and out-of-range pads.
    for (int s = 0; s < SLOTS_PER_PAD; s++)
      send_cmd(CMD_LOAD, 0, 0, s, (s == 0) ? 0 : (s == 1) ? 127 : (s == 2) ? 128 :
               (s == 3) ? 255 : 40 + s, 1'b1);
    send_cmd(CMD_LOAD, 1, 0, 4, 44, 1'b1);
    send_cmd(CMD_LOAD, 2, 0, 0, 50, 1'b0);
    send_cmd(CMD_LOAD, 15, 0, 0, 70, 1'b1);
    send_cmd(CMD_PRESS, 0, 127, 0, 0, 1'b0);
    send_cmd(CMD_PRESS, 1, 0, 7, 255, 1'b1);
    send_cmd(CMD_PRESS, 2, 64, 0, 0, 1'b0);
    send_cmd(CMD_PRESS, 9, 5, 0, 0, 1'b0);
    repeat (8) send_cmd(CMD_TICK, 0, 0, 0, 0, 1'b0);
    send_cmd(CMD_RELEASE, 0, 0, 0, 0, 1'b0);
    send_cmd(CMD_RELEASE, 1, 0, 0, 0, 1'b0);
    send_cmd(CMD_RELEASE, 2, 0, 0, 0, 1'b0);
    send_cmd(CMD_RELEASE, 0, 0, 0, 0, 1'b0);
    send_cmd(CMD_RELEASE, 12, 0, 0, 0, 1'b0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_quiet();
      write_reg(REG_SEND_DELAY, delays[ph]);
      write_reg(REG_CHANNEL, chans[ph]);
      send_idle_pct = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      // A long delay lets presses pile up in the queue.
      random_phase(ph == 2 ? 85 : 65);
    end

    wait_quiet();
    $display("%0d items sent over %0d settings; %0d note-ons, %0d note-offs, %0d drops",
             sb.items_seen, PHASE_COUNT, sb.ons_seen, sb.offs_seen, sb.drops_seen);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

FILE: pad_note_delay_and_release.f
hw/rtl/pndr_pkg.sv
hw/rtl/pndr_if.sv
hw/rtl/pad_note_delay_and_release.sv
sim/tb_pad_note_delay_and_release.sv
